/* src/gcfp_pkg.sv */
// Shared types and constants for the command FIFO parser.
// Used by the channel interfaces, the front, queue and back modules and the checker.
package gcfp_pkg;

	localparam int WORD_W          = 32;
	localparam int METHOD_W        = 18;
	localparam int COUNT_W         = 11;
	localparam int COUNT_LSB       = 18;
	localparam int CFG_IDX_W       = 1;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [WORD_W-1:0] JUMP_MASK   = 32'h2000_0000;
	localparam logic [WORD_W-1:0] CALL_MASK   = 32'h0000_0002;
	localparam logic [WORD_W-1:0] RET_MASK    = 32'hffff_0003;
	localparam logic [WORD_W-1:0] RET_PATTERN = 32'h0002_0000;
	localparam logic [WORD_W-1:0] OFFSET_STEP = 32'd4;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_ARG    = 3'd1,
		KIND_JUMP   = 3'd2,
		KIND_CALL   = 3'd3,
		KIND_RET    = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PUT_OFFSET   = 1'b0,
		REG_START_OFFSET = 1'b1
	} reg_idx_t;

	// One configuration write as seen by the front and back modules.
	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [WORD_W-1:0]    data;
	} cfg_wr_t;

	// A classified command word, everything but the drained flag.
	typedef struct packed {
		kind_t               kind;
		logic [METHOD_W-1:0] method;
		logic [COUNT_W-1:0]  arg_count;
		logic [COUNT_W-1:0]  arg_index;
		logic [WORD_W-1:0]   arg_data;
		logic                last_arg;
		logic [WORD_W-1:0]   next_offset;
	} item_t;

endpackage

/* src/gcfp_cmd_if.sv */
// Input channel carrying one command buffer word per transfer.
// Depends on gcfp_pkg for the word width.
interface gcfp_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [gcfp_pkg::WORD_W-1:0] word;

	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface

/* src/gcfp_rsp_if.sv */
// Output channel carrying one parsed result per transfer.
// Depends on gcfp_pkg for the kind type and field widths.
interface gcfp_rsp_if;
	logic                          valid;
	logic                          ready;
	gcfp_pkg::kind_t               kind;
	logic [gcfp_pkg::METHOD_W-1:0] method;
	logic [gcfp_pkg::COUNT_W-1:0]  arg_count;
	logic [gcfp_pkg::COUNT_W-1:0]  arg_index;
	logic [gcfp_pkg::WORD_W-1:0]   arg_data;
	logic                          last_arg;
	logic [gcfp_pkg::WORD_W-1:0]   next_offset;
	logic                          drained;

	modport source (output valid, output kind, output method, output arg_count,
		output arg_index, output arg_data, output last_arg, output next_offset,
		output drained, input ready);
	modport sink   (input valid, input kind, input method, input arg_count,
		input arg_index, input arg_data, input last_arg, input next_offset,
		input drained, output ready);
endinterface

/* src/gcfp_front.sv */
// Front end: accepts command words, decodes headers and tracks argument runs and the get offset.
// Depends on gcfp_pkg and gcfp_cmd_if; pushes classified items into gcfp_queue.
module gcfp_front (
	input  logic              clk,
	input  logic              arst_n,
	gcfp_cmd_if.sink          cmd,
	input  gcfp_pkg::cfg_wr_t cfg,
	input  logic              q_ready,
	output logic              push,
	output gcfp_pkg::item_t   item
);

	logic [gcfp_pkg::WORD_W-1:0]   fetch_q;
	logic [gcfp_pkg::COUNT_W-1:0]  args_left_q;
	logic [gcfp_pkg::METHOD_W-1:0] method_q;
	logic [gcfp_pkg::COUNT_W-1:0]  arg_pos_q;
	logic [gcfp_pkg::COUNT_W-1:0]  arg_total_q;

	logic [gcfp_pkg::WORD_W-1:0]   seq_offset;
	logic [gcfp_pkg::METHOD_W-1:0] hdr_method;
	logic [gcfp_pkg::COUNT_W-1:0]  hdr_count;

	assign cmd.ready  = q_ready;
	assign push       = cmd.valid && q_ready;
	assign seq_offset = fetch_q + gcfp_pkg::OFFSET_STEP;
	assign hdr_method = cmd.word[gcfp_pkg::METHOD_W-1:0];
	assign hdr_count  = cmd.word[gcfp_pkg::COUNT_LSB +: gcfp_pkg::COUNT_W];

	always_comb begin
		item             = '0;
		item.kind        = gcfp_pkg::KIND_HEADER;
		item.next_offset = seq_offset;
		if (args_left_q != '0) begin
			item.kind      = gcfp_pkg::KIND_ARG;
			item.method    = method_q;
			item.arg_count = arg_total_q;
			item.arg_index = arg_pos_q;
			item.arg_data  = cmd.word;
			item.last_arg  = (args_left_q == gcfp_pkg::COUNT_W'(1));
		end else if ((cmd.word & gcfp_pkg::JUMP_MASK) != '0) begin
			item.kind        = gcfp_pkg::KIND_JUMP;
			item.next_offset = cmd.word & ~gcfp_pkg::JUMP_MASK;
		end else if ((cmd.word & gcfp_pkg::CALL_MASK) != '0) begin
			item.kind = gcfp_pkg::KIND_CALL;
		end else if ((cmd.word & gcfp_pkg::RET_MASK) == gcfp_pkg::RET_PATTERN) begin
			item.kind = gcfp_pkg::KIND_RET;
		end else begin
			item.method    = hdr_method;
			item.arg_count = hdr_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_q     <= '0;
			args_left_q <= '0;
			method_q    <= '0;
			arg_pos_q   <= '0;
			arg_total_q <= '0;
		end else if (cfg.we && cfg.index == gcfp_pkg::REG_START_OFFSET) begin
			// Loading a new start offset abandons any open argument run.
			fetch_q     <= cfg.data;
			args_left_q <= '0;
		end else if (push) begin
			fetch_q <= item.next_offset;
			if (item.kind == gcfp_pkg::KIND_ARG) begin
				args_left_q <= args_left_q - gcfp_pkg::COUNT_W'(1);
				arg_pos_q   <= arg_pos_q + gcfp_pkg::COUNT_W'(1);
			end else if (item.kind == gcfp_pkg::KIND_HEADER) begin
				args_left_q <= hdr_count;
				method_q    <= hdr_method;
				arg_total_q <= hdr_count;
				arg_pos_q   <= '0;
			end
		end
	end

endmodule

/* src/gcfp_queue.sv */
// Short register queue of classified items between the front and back modules.
// Depends on gcfp_pkg for the item type.
module gcfp_queue #(
	parameter int DEPTH = gcfp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gcfp_pkg::item_t push_item,
	output logic            push_ready,
	input  logic            pop,
	output logic            pop_valid,
	output gcfp_pkg::item_t pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	gcfp_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* src/gcfp_back.sv */
// Back end: drains the queue, checks the next offset against the put offset, holds the result.
// Depends on gcfp_pkg and gcfp_rsp_if.
module gcfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gcfp_pkg::cfg_wr_t cfg,
	input  logic              q_valid,
	input  gcfp_pkg::item_t   q_item,
	output logic              pop,
	gcfp_rsp_if.source        rsp
);

	logic [gcfp_pkg::WORD_W-1:0] put_q;
	logic                        valid_q;
	gcfp_pkg::item_t             rec_q;
	logic                        drained_q;

	// The output register refills in the same cycle that its result is taken.
	assign pop = q_valid && (!valid_q || rsp.ready);

	assign rsp.valid       = valid_q;
	assign rsp.kind        = rec_q.kind;
	assign rsp.method      = rec_q.method;
	assign rsp.arg_count   = rec_q.arg_count;
	assign rsp.arg_index   = rec_q.arg_index;
	assign rsp.arg_data    = rec_q.arg_data;
	assign rsp.last_arg    = rec_q.last_arg;
	assign rsp.next_offset = rec_q.next_offset;
	assign rsp.drained     = drained_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q     <= q_item;
			drained_q <= (q_item.next_offset == put_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg.we && cfg.index == gcfp_pkg::REG_PUT_OFFSET) begin
				put_q <= cfg.data;
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/gpu_command_fifo_parser.sv */
// Command buffer parser: one command word in, one parsed result out per transfer.
// Channel cmd carries the word fetched at the current get offset; channel rsp carries
// the kind, method, argument count, index and data, last mark, next offset and drained flag.
// Configuration: cfg_we with cfg_index 0 writes the put offset, index 1 loads the start
// offset into the fetch offset and closes any open argument run. Write only while idle.
// Throughput: one word per cycle while the queue is not full; the front decodes a word
// in the cycle it is accepted. A result reaches rsp by way of the queue entry written at
// its word's transfer and then the output register.
// The queue holds QUEUE_DEPTH items; cmd.ready drops only when it is full, so with rsp
// stalled the block takes QUEUE_DEPTH words beyond the one in the output register.
// The parser does not stop at the put offset: drained only flags it, the source decides.
// Reset clears the queue and output valid, sets both offsets to zero and closes any run.
// Depends on gcfp_pkg, the channel interfaces and gcfp_front, gcfp_queue, gcfp_back.
module gpu_command_fifo_parser #(
	parameter int QUEUE_DEPTH = gcfp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	gcfp_cmd_if.sink                       cmd,
	gcfp_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [gcfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcfp_pkg::WORD_W-1:0]    cfg_data
);

	gcfp_pkg::cfg_wr_t cfg;
	gcfp_pkg::item_t   push_item;
	gcfp_pkg::item_t   pop_item;
	logic              push;
	logic              push_ready;
	logic              pop;
	logic              pop_valid;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	gcfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cfg     (cfg),
		.q_ready (push_ready),
		.push    (push),
		.item    (push_item)
	);

	gcfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item)
	);

	gcfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (pop_valid),
		.q_item  (pop_item),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

/* src/gcfp_checker.sv */
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on gcfp_pkg for the kind codes.
module gcfp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          valid,
	input logic                          ready,
	input logic [2:0]                    kind,
	input logic [gcfp_pkg::METHOD_W-1:0] method,
	input logic [gcfp_pkg::COUNT_W-1:0]  arg_count,
	input logic [gcfp_pkg::COUNT_W-1:0]  arg_index,
	input logic [gcfp_pkg::WORD_W-1:0]   arg_data,
	input logic                          last_arg,
	input logic [gcfp_pkg::WORD_W-1:0]   next_offset
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(kind) && $stable(arg_data) && $stable(next_offset))
		else $error("result changed while stalled");

	// Only arguments carry an index, data or a last mark.
	a_non_arg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind != gcfp_pkg::KIND_ARG |-> arg_index == '0 && arg_data == '0 && !last_arg)
		else $error("argument fields set on a non-argument result");

	a_ctrl_flow_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == gcfp_pkg::KIND_JUMP || kind == gcfp_pkg::KIND_CALL ||
		kind == gcfp_pkg::KIND_RET) |-> method == '0 && arg_count == '0)
		else $error("method or count set on a jump, call or return");

	// The last argument of a run sits at index count minus one.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == gcfp_pkg::KIND_ARG && last_arg |->
		arg_index == arg_count - gcfp_pkg::COUNT_W'(1))
		else $error("last argument at the wrong index");

endmodule

bind gpu_command_fifo_parser gcfp_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (rsp.valid),
	.ready       (rsp.ready),
	.kind        (rsp.kind),
	.method      (rsp.method),
	.arg_count   (rsp.arg_count),
	.arg_index   (rsp.arg_index),
	.arg_data    (rsp.arg_data),
	.last_arg    (rsp.last_arg),
	.next_offset (rsp.next_offset)
);

/* test/gcfp_checker.sv */
// Scoreboard for the command FIFO parser: follows register writes and word transfers,
// predicts each parsed result and compares the results in order, field by field.
// Depends on gcfp_pkg and the gcfp_cmd_if and gcfp_rsp_if channel interfaces.
module gcfp_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	gcfp_cmd_if                            cmd,
	gcfp_rsp_if                            rsp,
	input  logic                           cfg_we,
	input  logic [gcfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcfp_pkg::WORD_W-1:0]    cfg_data,
	output int                             fails,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		gcfp_pkg::item_t fields;
		logic            drained;
	} parse_result_t;

	parse_result_t                 expected_q[$];
	logic [gcfp_pkg::WORD_W-1:0]   put_offset;
	logic [gcfp_pkg::WORD_W-1:0]   get_offset;
	logic [gcfp_pkg::COUNT_W-1:0]  run_left;
	logic [gcfp_pkg::COUNT_W-1:0]  run_pos;
	logic [gcfp_pkg::COUNT_W-1:0]  run_total;
	logic [gcfp_pkg::METHOD_W-1:0] run_method;

	// Classifies one word at the current get offset and advances the parser state.
	function automatic parse_result_t parse_word(input logic [gcfp_pkg::WORD_W-1:0] w);
		parse_result_t r;
		r = '0;
		if (run_left != '0) begin
			r.fields.kind        = gcfp_pkg::KIND_ARG;
			r.fields.method      = run_method;
			r.fields.arg_count   = run_total;
			r.fields.arg_index   = run_pos;
			r.fields.arg_data    = w;
			r.fields.last_arg    = (run_left == 1);
			r.fields.next_offset = get_offset + gcfp_pkg::OFFSET_STEP;
			run_left = run_left - 1'b1;
			run_pos  = run_pos + 1'b1;
		end else if ((w & gcfp_pkg::JUMP_MASK) != '0) begin
			r.fields.kind        = gcfp_pkg::KIND_JUMP;
			r.fields.next_offset = w & ~gcfp_pkg::JUMP_MASK;
		end else if ((w & gcfp_pkg::CALL_MASK) != '0) begin
			r.fields.kind        = gcfp_pkg::KIND_CALL;
			r.fields.next_offset = get_offset + gcfp_pkg::OFFSET_STEP;
		end else if ((w & gcfp_pkg::RET_MASK) == gcfp_pkg::RET_PATTERN) begin
			r.fields.kind        = gcfp_pkg::KIND_RET;
			r.fields.next_offset = get_offset + gcfp_pkg::OFFSET_STEP;
		end else begin
			r.fields.kind        = gcfp_pkg::KIND_HEADER;
			r.fields.method      = w[gcfp_pkg::METHOD_W-1:0];
			r.fields.arg_count   = w[gcfp_pkg::COUNT_LSB +: gcfp_pkg::COUNT_W];
			r.fields.next_offset = get_offset + gcfp_pkg::OFFSET_STEP;
			run_method = w[gcfp_pkg::METHOD_W-1:0];
			run_total  = w[gcfp_pkg::COUNT_LSB +: gcfp_pkg::COUNT_W];
			run_left   = w[gcfp_pkg::COUNT_LSB +: gcfp_pkg::COUNT_W];
			run_pos    = '0;
		end
		get_offset = r.fields.next_offset;
		r.drained  = (get_offset == put_offset);
		return r;
	endfunction

	function automatic void check_field(input string name,
			input logic [gcfp_pkg::WORD_W-1:0] want, input logic [gcfp_pkg::WORD_W-1:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		parse_result_t fresh;
		if (!arst_n) begin
			expected_q.delete();
			put_offset = '0;
			get_offset = '0;
			run_left   = '0;
			run_pos    = '0;
			run_total  = '0;
			run_method = '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gcfp_pkg::REG_PUT_OFFSET) begin
					put_offset = cfg_data;
				end else begin
					// Loading the start offset also drops any open argument run.
					get_offset = cfg_data;
					run_left   = '0;
				end
			end
			if (cmd.valid && cmd.ready) begin
				fresh = parse_word(cmd.word);
				expected_q.insert(expected_q.size(), fresh);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					fails++;
					$display("%0t: result transfer with nothing expected, kind %0d offset %h",
						$time, rsp.kind, rsp.next_offset);
				end else begin
					want = expected_q.pop_front();
					check_field("kind", want.fields.kind, rsp.kind);
					check_field("method", want.fields.method, rsp.method);
					check_field("arg_count", want.fields.arg_count, rsp.arg_count);
					check_field("arg_index", want.fields.arg_index, rsp.arg_index);
					check_field("arg_data", want.fields.arg_data, rsp.arg_data);
					check_field("last_arg", want.fields.last_arg, rsp.last_arg);
					check_field("next_offset", want.fields.next_offset, rsp.next_offset);
					check_field("drained", want.drained, rsp.drained);
				end
			end
		end
		outstanding = expected_q.size();
	end

endmodule

/* test/tb.sv */
// Top of the command FIFO parser testbench: clock, reset, register writes and word stimulus
// with random idle bursts on both channels; gcfp_scoreboard does the prediction and comparison.
// Depends on gcfp_pkg, the channel interfaces, gpu_command_fifo_parser and gcfp_scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 110;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [gcfp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gcfp_pkg::WORD_W-1:0]    cfg_data;
	int                             fails;
	int                             outstanding;
	int                             burst_odds;
	int                             rsp_hold;
	int                             quiet;
	int                             words_sent;
	logic [gcfp_pkg::WORD_W-1:0]    put_now;

	gcfp_cmd_if cmd ();
	gcfp_rsp_if rsp ();

	gpu_command_fifo_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gcfp_scoreboard chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Result side: ready drops for random bursts while bursts are enabled.
	always @(negedge clk) begin
		if (rsp_hold > 0)
			rsp_hold--;
		else if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1)
			rsp_hold = $urandom_range(1, 15);
		rsp.ready <= (rsp_hold == 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet == QUIET_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic logic is_method_header(input logic [gcfp_pkg::WORD_W-1:0] w);
		return (w & gcfp_pkg::JUMP_MASK) == '0 && (w & gcfp_pkg::CALL_MASK) == '0 &&
			(w & gcfp_pkg::RET_MASK) != gcfp_pkg::RET_PATTERN;
	endfunction

	function automatic logic [gcfp_pkg::WORD_W-1:0] header_word(input int count);
		logic [gcfp_pkg::WORD_W-1:0] w;
		w = $urandom() & ~(gcfp_pkg::JUMP_MASK | gcfp_pkg::CALL_MASK);
		w[gcfp_pkg::COUNT_LSB +: gcfp_pkg::COUNT_W] = count[gcfp_pkg::COUNT_W-1:0];
		if ((w & gcfp_pkg::RET_MASK) == gcfp_pkg::RET_PATTERN)
			w[gcfp_pkg::WORD_W-1] = 1'b1;
		return w;
	endfunction

	// Jump targets favor the put offset so that drained shows up often.
	function automatic logic [gcfp_pkg::WORD_W-1:0] jump_word();
		case ($urandom_range(0, 2))
			0: return gcfp_pkg::JUMP_MASK | put_now;
			1: return gcfp_pkg::JUMP_MASK |
				(put_now - gcfp_pkg::OFFSET_STEP * $urandom_range(1, 12));
			default: return gcfp_pkg::JUMP_MASK | $urandom();
		endcase
	endfunction

	function automatic logic [gcfp_pkg::WORD_W-1:0] arg_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return gcfp_pkg::JUMP_MASK | $urandom();
			default: return $urandom();
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_word(input logic [gcfp_pkg::WORD_W-1:0] w);
		if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.word  <= w;
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_command(input logic [gcfp_pkg::WORD_W-1:0] w);
		int n;
		send_word(w);
		if (is_method_header(w)) begin
			n = int'(w[gcfp_pkg::COUNT_LSB +: gcfp_pkg::COUNT_W]);
			repeat (n) send_word(arg_word());
		end
	endtask

	task automatic random_command();
		int pick;
		logic [gcfp_pkg::WORD_W-1:0] w;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			w = header_word($urandom_range(0, 8));
		else if (pick < 60)
			w = header_word($urandom_range(9, 40));
		else if (pick < 70)
			w = jump_word();
		else if (pick < 78)
			w = ($urandom() & ~gcfp_pkg::JUMP_MASK) | gcfp_pkg::CALL_MASK;
		else if (pick < 86)
			w = gcfp_pkg::RET_PATTERN | ($urandom() & 32'h0000_fffc);
		else begin
			// Raw noise; the count is cut short in case it decodes as a header.
			w = $urandom();
			w[28:22] = '0;
		end
		send_command(w);
	endtask

	// Stops sending and waits until every transfer has produced its result.
	task automatic settle();
		cmd.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input gcfp_pkg::reg_idx_t idx,
			input logic [gcfp_pkg::WORD_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [gcfp_pkg::WORD_W-1:0] start_at;
		int                          stop_at;
		cmd.valid  = 1'b0;
		cmd.word   = '0;
		rsp.ready  = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = gcfp_pkg::REG_PUT_OFFSET;
		cfg_data   = '0;
		arst_n     = 1'b0;
		burst_odds = 4;
		put_now    = '0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words against the reset register values.
		send_word(32'h0000_0000);
		send_word(gcfp_pkg::JUMP_MASK);
		send_word(32'hffff_ffff);
		send_word(gcfp_pkg::CALL_MASK);
		send_word(32'hdfff_ffff);
		send_word(gcfp_pkg::RET_PATTERN);
		send_word(gcfp_pkg::RET_PATTERN | 32'h0000_fffc);
		send_word(32'hc003_fffd);
		send_word(32'h0004_0001);
		send_word(32'hffff_ffff);
		send_word(32'h000c_1234);
		send_word(32'h0000_0000);
		send_word(32'h2000_0002);
		send_word(gcfp_pkg::RET_PATTERN);
		// Longest run, cut short by a start offset write in the middle.
		send_word(32'h1ffc_0000);
		send_word(32'hffff_ffff);
		send_word(32'h0000_0000);
		settle();
		put_now = 32'h0000_0104;
		write_reg(gcfp_pkg::REG_PUT_OFFSET, put_now);
		write_reg(gcfp_pkg::REG_START_OFFSET, 32'h0000_0100);
		send_word(32'h0000_0008);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					start_at = '0;
					put_now  = gcfp_pkg::OFFSET_STEP * $urandom_range(8, 40);
				end
				1: begin
					start_at = 32'hffff_fff0;
					put_now  = 32'h0000_0010;
				end
				2: begin
					start_at = 32'h0000_0003;
					put_now  = 32'hffff_ffff;
				end
				4: begin
					start_at = $urandom();
					put_now  = $urandom();
				end
				5: begin
					start_at = '0;
					put_now  = '0;
				end
				default: begin
					start_at = $urandom() & ~gcfp_pkg::JUMP_MASK;
					put_now  = start_at + gcfp_pkg::OFFSET_STEP * $urandom_range(8, 40);
				end
			endcase
			settle();
			if ($urandom_range(0, 1) == 0) begin
				write_reg(gcfp_pkg::REG_PUT_OFFSET, put_now);
				write_reg(gcfp_pkg::REG_START_OFFSET, start_at);
			end else begin
				write_reg(gcfp_pkg::REG_START_OFFSET, start_at);
				write_reg(gcfp_pkg::REG_PUT_OFFSET, put_now);
			end
			burst_odds = (p == PHASES - 1 || p % 3 == 0) ? 0 : $urandom_range(3, 12);
			if (p == 3)
				send_command(header_word(200));
			stop_at = words_sent + PHASE_WORDS;
			while (words_sent < stop_at) random_command();
		end

		settle();
		repeat (5) @(negedge clk);
		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

/* gpu_command_fifo_parser.f */
src/gcfp_pkg.sv
src/gcfp_cmd_if.sv
src/gcfp_rsp_if.sv
src/gcfp_front.sv
src/gcfp_queue.sv
src/gcfp_back.sv
src/gpu_command_fifo_parser.sv
src/gcfp_checker.sv
test/gcfp_checker.sv
test/tb.sv
